### rtl/tint_pkg.sv
// ----------------------------------------------------------------------------
// tint_pkg
// Shared types and constants of the table-interpolated temperature converter.
// ----------------------------------------------------------------------------
package tint_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int LEN_W       = 6;
    localparam int NPT_W       = ($clog2(TABLE_DEPTH + 1) > LEN_W) ?
                                 $clog2(TABLE_DEPTH + 1) : LEN_W;
    localparam int IDX_W       = 5;
    localparam int RES_W       = 24;
    localparam int TMP_W       = 16;
    localparam int ENT_W       = RES_W + TMP_W;
    localparam int NUM_W       = 43;
    localparam int MAG_W       = NUM_W - 1;
    localparam int DIV_CNT_W   = $clog2(MAG_W);
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;

    localparam logic [LEN_W-1:0] TBL_LEN_RST = 6'd2;

    // register select bit of paddr
    localparam logic REG_TABLE_LENGTH = 1'b0;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_CONV = 1'b1;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_HOT  = 2'd1;
    localparam logic [1:0] ST_COLD = 2'd2;

    typedef struct packed {
        logic                    func;
        logic [IDX_W-1:0]        entry_index;
        logic [RES_W-1:0]        entry_resistance;
        logic signed [TMP_W-1:0] entry_temperature;
        logic [RES_W-1:0]        resistance;
    } t_in_word;

    typedef struct packed {
        logic signed [TMP_W-1:0] temperature;
        logic [1:0]              status;
        logic [1:0]              sticky_fault;
    } t_out_word;

    typedef struct packed {
        logic             start;
        logic [MAG_W-1:0] dividend;
        logic [RES_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [MAG_W-1:0] quotient;
    } t_div_rsp;

endpackage

### rtl/tint_ram.sv
// ----------------------------------------------------------------------------
// tint_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tint_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/tint_div.sv
// ----------------------------------------------------------------------------
// tint_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tint_div
    import tint_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [RES_W-1:0]     r_rem, n_rem;
    logic [MAG_W-1:0]     r_quo, n_quo;
    logic [RES_W-1:0]     r_dvs, n_dvs;

    logic [RES_W:0]       sh;
    logic [RES_W:0]       dif;
    logic                 ge;

    assign sh  = {r_rem, r_quo[MAG_W-1]};
    assign ge  = (sh >= {1'b0, r_dvs});
    assign dif = sh - {1'b0, r_dvs};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_req.dividend;
            n_dvs  = i_req.divisor;
        end else if (r_busy) begin
            n_rem = ge ? dif[RES_W-1:0] : sh[RES_W-1:0];
            n_quo = {r_quo[MAG_W-2:0], ge};
            n_cnt = r_cnt + DIV_CNT_W'(1);
            if (r_cnt == DIV_CNT_W'(MAG_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("divider started while busy");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy) && !r_busy)
        else $error("divider done without a running division");

endmodule

### rtl/table_interpolated_temperature_core.sv
// ----------------------------------------------------------------------------
// table_interpolated_temperature_core
// Thermistor resistance to temperature by piecewise-linear table lookup.
//
// Input words arrive on i_in_valid/o_in_ready. A load word writes one
// calibration point into the table RAM in its accept cycle and yields no
// result. A convert word reads the first and last points, then walks the
// table one point at a time until a bracketing pair is found or the last
// point is reached, forms the numerator with one shared multiplier in the
// states S_MUL1 and S_MUL2 and divides it with a one-bit-per-cycle divider.
// Out-of-range inputs and equal neighbor resistances skip the divider.
// o_in_ready is high only while idle, so one word is in flight at a time.
// A result waits in the output register while the receiver stalls; the next
// word can be accepted meanwhile, and its result waits until that register
// is free. Reset clears the control state, the sticky fault code and sets
// table_length to 2; table contents are undefined until loaded.
// The table_length register sits at byte address 0 of the APB port.
// ----------------------------------------------------------------------------
module table_interpolated_temperature_core
    import tint_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_word          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_word         o_out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_FIRST,
        S_RD_LAST,
        S_CHECK,
        S_SRCH_WAIT,
        S_SRCH,
        S_MUL1,
        S_MUL2,
        S_SUM,
        S_DIVGO,
        S_DIV,
        S_DONE
    } t_state;

    t_state                  r_state, n_state;
    logic [LEN_W-1:0]        r_tbl_len, n_tbl_len;
    logic [ADDR_W-1:0]       r_rd_addr, n_rd_addr;
    logic [RES_W-1:0]        r_r, n_r;
    logic [RES_W-1:0]        r_prev_res, n_prev_res;
    logic signed [TMP_W-1:0] r_prev_tmp, n_prev_tmp;
    logic [RES_W-1:0]        r_cur_res, n_cur_res;
    logic signed [TMP_W-1:0] r_cur_tmp, n_cur_tmp;
    logic signed [TMP_W-1:0] r_last_tmp, n_last_tmp;
    logic signed [NUM_W-1:0] r_prod, n_prod;
    logic signed [NUM_W-1:0] r_acc, n_acc;
    logic                    r_neg, n_neg;
    logic signed [TMP_W-1:0] r_res_tmp, n_res_tmp;
    logic [1:0]              r_res_st, n_res_st;
    logic [1:0]              r_fault, n_fault;
    logic                    r_out_valid, n_out_valid;
    t_out_word               r_out, n_out;

    logic                    in_acc;
    logic                    cfg_wr;
    logic                    ram_we;
    logic [ENT_W-1:0]        ram_wdata;
    logic [ENT_W-1:0]        ram_rdata;
    logic [RES_W-1:0]        rd_res;
    logic signed [TMP_W-1:0] rd_tmp;
    logic [NPT_W-1:0]        tl_ext;
    logic [NPT_W-1:0]        npts;
    logic [ADDR_W-1:0]       last_idx;
    logic [RES_W-1:0]        dr;
    logic [RES_W-1:0]        dx;
    logic signed [RES_W:0]   mul_a;
    logic signed [TMP_W+1:0] mul_b;
    logic signed [NUM_W-1:0] mul_p;
    logic signed [NUM_W-1:0] acc_neg;
    logic [MAG_W-1:0]        acc_mag;
    logic [TMP_W:0]          q_lo;
    logic [TMP_W:0]          q_sgn;
    t_div_req                div_req;
    t_div_rsp                div_rsp;

    assign in_acc    = i_in_valid && o_in_ready;
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign ram_we    = in_acc && (i_in_data.func == FUNC_LOAD)
                       && (i_in_data.entry_index < TABLE_DEPTH);
    assign ram_wdata = {i_in_data.entry_resistance, i_in_data.entry_temperature};
    assign rd_res    = ram_rdata[ENT_W-1:TMP_W];
    assign rd_tmp    = ram_rdata[TMP_W-1:0];

    // table length clamped to 2..depth
    assign tl_ext   = NPT_W'(r_tbl_len);
    assign npts     = (tl_ext < NPT_W'(2)) ? NPT_W'(2) :
                      (tl_ext > NPT_W'(TABLE_DEPTH)) ? NPT_W'(TABLE_DEPTH) : tl_ext;
    assign last_idx = ADDR_W'(npts - NPT_W'(1));

    assign dr      = r_cur_res - r_prev_res;
    assign dx      = r_r - r_prev_res;
    assign mul_p   = NUM_W'(mul_a) * NUM_W'(mul_b);
    assign acc_neg = -r_acc;
    assign acc_mag = r_acc[NUM_W-1] ? acc_neg[MAG_W-1:0] : r_acc[MAG_W-1:0];
    assign q_lo    = div_rsp.quotient[TMP_W:0];
    assign q_sgn   = r_neg ? -q_lo : q_lo;

    // shared multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_MUL1: begin
                mul_a = signed'({1'b0, dr});
                mul_b = (TMP_W+2)'(r_prev_tmp);
            end
            S_MUL2: begin
                mul_a = signed'({1'b0, dx});
                mul_b = (TMP_W+2)'(r_cur_tmp) - (TMP_W+2)'(r_prev_tmp);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        div_req.start    = (r_state == S_DIVGO);
        div_req.dividend = acc_mag;
        div_req.divisor  = dr;
    end

    always_comb begin
        n_state     = r_state;
        n_tbl_len   = r_tbl_len;
        n_rd_addr   = r_rd_addr;
        n_r         = r_r;
        n_prev_res  = r_prev_res;
        n_prev_tmp  = r_prev_tmp;
        n_cur_res   = r_cur_res;
        n_cur_tmp   = r_cur_tmp;
        n_last_tmp  = r_last_tmp;
        n_prod      = r_prod;
        n_acc       = r_acc;
        n_neg       = r_neg;
        n_res_tmp   = r_res_tmp;
        n_res_st    = r_res_st;
        n_fault     = r_fault;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        if (cfg_wr && (paddr[2] == REG_TABLE_LENGTH)) begin
            n_tbl_len = pwdata[LEN_W-1:0];
        end

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc && (i_in_data.func == FUNC_CONV)) begin
                    n_r       = i_in_data.resistance;
                    n_rd_addr = '0;
                    n_state   = S_RD_FIRST;
                end
            end
            S_RD_FIRST: begin
                n_rd_addr = last_idx;
                n_state   = S_RD_LAST;
            end
            S_RD_LAST: begin
                n_prev_res = rd_res;
                n_prev_tmp = rd_tmp;
                n_state    = S_CHECK;
            end
            S_CHECK: begin
                if (r_r < r_prev_res) begin
                    n_res_tmp = r_prev_tmp;
                    n_res_st  = ST_HOT;
                    n_fault   = ST_HOT;
                    n_state   = S_DONE;
                end else if (r_r > rd_res) begin
                    n_res_tmp = rd_tmp;
                    n_res_st  = ST_COLD;
                    n_fault   = ST_COLD;
                    n_state   = S_DONE;
                end else begin
                    n_last_tmp = rd_tmp;
                    n_rd_addr  = ADDR_W'(1);
                    n_state    = S_SRCH_WAIT;
                end
            end
            S_SRCH_WAIT: begin
                n_state = S_SRCH;
            end
            S_SRCH: begin
                if ((r_prev_res <= r_r) && (rd_res >= r_r)) begin
                    n_cur_res = rd_res;
                    n_cur_tmp = rd_tmp;
                    n_state   = S_MUL1;
                end else begin
                    n_prev_res = rd_res;
                    n_prev_tmp = rd_tmp;
                    if (r_rd_addr == last_idx) begin
                        // no bracketing pair in an unsorted table
                        n_res_tmp = r_last_tmp;
                        n_res_st  = ST_OK;
                        n_state   = S_DONE;
                    end else begin
                        n_rd_addr = r_rd_addr + ADDR_W'(1);
                        n_state   = S_SRCH_WAIT;
                    end
                end
            end
            S_MUL1: begin
                if (dr == '0) begin
                    n_res_tmp = r_prev_tmp;
                    n_res_st  = ST_OK;
                    n_state   = S_DONE;
                end else begin
                    n_prod  = mul_p;
                    n_state = S_MUL2;
                end
            end
            S_MUL2: begin
                n_prod  = mul_p;
                n_acc   = r_prod;
                n_state = S_SUM;
            end
            S_SUM: begin
                n_acc   = r_acc + r_prod;
                n_state = S_DIVGO;
            end
            S_DIVGO: begin
                n_neg   = r_acc[NUM_W-1];
                n_state = S_DIV;
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    n_res_tmp = q_sgn[TMP_W-1:0];
                    n_res_st  = ST_OK;
                    n_state   = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out.temperature  = r_res_tmp;
                    n_out.status       = r_res_st;
                    n_out.sticky_fault = r_fault;
                    n_out_valid        = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tbl_len   <= TBL_LEN_RST;
            r_fault     <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_tbl_len   <= n_tbl_len;
            r_fault     <= n_fault;
            r_out_valid <= n_out_valid;
        end
        r_rd_addr  <= n_rd_addr;
        r_r        <= n_r;
        r_prev_res <= n_prev_res;
        r_prev_tmp <= n_prev_tmp;
        r_cur_res  <= n_cur_res;
        r_cur_tmp  <= n_cur_tmp;
        r_last_tmp <= n_last_tmp;
        r_prod     <= n_prod;
        r_acc      <= n_acc;
        r_neg      <= n_neg;
        r_res_tmp  <= n_res_tmp;
        r_res_st   <= n_res_st;
        r_out      <= n_out;
    end

    tint_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ADDR_W'(i_in_data.entry_index)),
        .i_wdata (ram_wdata),
        .i_raddr (r_rd_addr),
        .o_rdata (ram_rdata)
    );

    tint_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign pready      = 1'b1;
    assign prdata      = (paddr[2] == REG_TABLE_LENGTH) ? APB_DW'(r_tbl_len) : '0;

    a_load_no_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_in_data.func == FUNC_LOAD)) |=> !$rose(r_out_valid))
        else $error("load produced a result word");

    a_word_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_DONE))
        else $error("result word raised outside the done step");

    a_fault_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status != ST_OK))
        |-> (o_out_data.sticky_fault == o_out_data.status))
        else $error("sticky fault disagrees with out-of-range status");

    a_div_only_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_DIV))
        else $error("quotient arrived outside the divide step");

endmodule
